// ===== sv/rrg_pkg.sv =====
// rrg_pkg: shared types, constants and codes of the render rate governor
// item and result payloads, register map, controller states and command/status bundles
// no dependencies
package rrg_pkg;

   localparam int AMT_W   = 32;
   localparam int COST_W  = 17;
   localparam int EST_W   = 18;
   localparam int THR_W   = 18;
   localparam int DWELL_W = 16;
   localparam int RATE_W  = 2;
   localparam int TICK_W  = 32;

   localparam int CALC_DEPTH_DEF = 12;
   localparam int DRAW_DEPTH_DEF = 8;

   localparam logic [COST_W-1:0] COST_CLAMP = COST_W'(100000);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_DEMOTE_FAST  = 3'd0;
   localparam logic [2:0] REG_PROMOTE_MID  = 3'd1;
   localparam logic [2:0] REG_DEMOTE_MID   = 3'd2;
   localparam logic [2:0] REG_PROMOTE_SLOW = 3'd3;
   localparam logic [2:0] REG_DWELL        = 3'd4;
   localparam logic [2:0] REG_BURST_RATE   = 3'd5;

   localparam logic [THR_W-1:0]   DEMOTE_FAST_RST  = THR_W'(20000);
   localparam logic [THR_W-1:0]   PROMOTE_MID_RST  = THR_W'(18000);
   localparam logic [THR_W-1:0]   DEMOTE_MID_RST   = THR_W'(30000);
   localparam logic [THR_W-1:0]   PROMOTE_SLOW_RST = THR_W'(25000);
   localparam logic [DWELL_W-1:0] DWELL_RST        = DWELL_W'(60);
   localparam logic [RATE_W-1:0]  BURST_RATE_RST   = RATE_W'(2);

   localparam logic [RATE_W-1:0] RATE_FAST = 2'd0;
   localparam logic [RATE_W-1:0] RATE_MID  = 2'd1;
   localparam logic [RATE_W-1:0] RATE_SLOW = 2'd2;
   localparam logic [RATE_W-1:0] RATE_BAD  = 2'd3;

   typedef enum logic [1:0] {
      KIND_CALC = 2'd0,
      KIND_DRAW = 2'd1,
      KIND_WAIT = 2'd2,
      KIND_TICK = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [AMT_W-1:0]  amount_us;
      logic              burst_active;
      logic              manual_override;
      logic [RATE_W-1:0] current_rate;
   } req_type;

   typedef struct packed {
      logic              set_request;
      logic [RATE_W-1:0] new_rate;
      logic [EST_W-1:0]  estimate_us;
      logic              burst_forced;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0]   demote_fast_to_mid_us;
      logic [THR_W-1:0]   promote_mid_to_fast_us;
      logic [THR_W-1:0]   demote_mid_to_slow_us;
      logic [THR_W-1:0]   promote_slow_to_mid_us;
      logic [DWELL_W-1:0] dwell_ticks;
      logic [RATE_W-1:0]  burst_rate;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic update;
      logic finish;
      logic decide;
   } cmd_type;

   typedef struct packed {
      kind_type item_kind;
      logic     div_done;
      logic     rsp_free;
   } status_type;

endpackage

// ===== sv/rrg_csr.sv =====
// rrg_csr: configuration register bank behind the apb-style port
// depends on rrg_pkg for the register map and reset values
module rrg_csr import rrg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.demote_fast_to_mid_us  <= DEMOTE_FAST_RST;
         cfg_ff.promote_mid_to_fast_us <= PROMOTE_MID_RST;
         cfg_ff.demote_mid_to_slow_us  <= DEMOTE_MID_RST;
         cfg_ff.promote_slow_to_mid_us <= PROMOTE_SLOW_RST;
         cfg_ff.dwell_ticks            <= DWELL_RST;
         cfg_ff.burst_rate             <= BURST_RATE_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DEMOTE_FAST:  cfg_ff.demote_fast_to_mid_us  <= csr_pwdata[THR_W-1:0];
            REG_PROMOTE_MID:  cfg_ff.promote_mid_to_fast_us <= csr_pwdata[THR_W-1:0];
            REG_DEMOTE_MID:   cfg_ff.demote_mid_to_slow_us  <= csr_pwdata[THR_W-1:0];
            REG_PROMOTE_SLOW: cfg_ff.promote_slow_to_mid_us <= csr_pwdata[THR_W-1:0];
            REG_DWELL:        cfg_ff.dwell_ticks            <= csr_pwdata[DWELL_W-1:0];
            REG_BURST_RATE:   cfg_ff.burst_rate             <= csr_pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DEMOTE_FAST:  csr_prdata = CSR_DATA_W'(cfg_ff.demote_fast_to_mid_us);
         REG_PROMOTE_MID:  csr_prdata = CSR_DATA_W'(cfg_ff.promote_mid_to_fast_us);
         REG_DEMOTE_MID:   csr_prdata = CSR_DATA_W'(cfg_ff.demote_mid_to_slow_us);
         REG_PROMOTE_SLOW: csr_prdata = CSR_DATA_W'(cfg_ff.promote_slow_to_mid_us);
         REG_DWELL:        csr_prdata = CSR_DATA_W'(cfg_ff.dwell_ticks);
         REG_BURST_RATE:   csr_prdata = CSR_DATA_W'(cfg_ff.burst_rate);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// ===== sv/rrg_ctrl.sv =====
// rrg_ctrl: sequencing state machine of the governor
// depends on rrg_pkg for state, command and status types
module rrg_ctrl import rrg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  kind_type   req_kind,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_kind == KIND_DRAW || req_kind == KIND_TICK)) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.item_kind == KIND_TICK) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_READ:   cmd.read   = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_DIVIDE: ;
         ST_FINISH: cmd.finish = 1'b1;
         ST_DECIDE: cmd.decide = status.rsp_free;
         default: ;
      endcase
   end

endmodule

// ===== sv/rrg_divider.sv =====
// rrg_divider: shared multi-cycle unsigned divider, two quotient bits per cycle
// depends on rrg_pkg for the quotient width
module rrg_divider import rrg_pkg::*; #(
   parameter int SUM_W = COST_W,
   parameter int CNT_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [COST_W-1:0] quotient
);

   localparam int DIV_W  = SUM_W + (SUM_W % 2);
   localparam int STEPS  = DIV_W / 2;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W-1:0]  work_ff, work_v;
   logic [CNT_W-1:0]  rem_ff, rem_v;
   logic [CNT_W-1:0]  divisor_ff;
   logic [CNT_W:0]    trial;

   always_comb begin
      rem_v  = rem_ff;
      work_v = work_ff;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
         trial  = {rem_v, work_v[DIV_W-1]};
         work_v = {work_v[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_v     = CNT_W'(trial - {1'b0, divisor_ff});
            work_v[0] = 1'b1;
         end else begin
            rem_v = trial[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff    <= DIV_W'(dividend);
         rem_ff     <= '0;
         divisor_ff <= divisor;
         step_ff    <= STEP_W'(STEPS - 1);
      end else if (busy_ff) begin
         work_ff <= work_v;
         rem_ff  <= rem_v;
         step_ff <= step_ff - 1'b1;
      end
   end

   assign done     = busy_ff && (step_ff == '0);
   assign quotient = work_ff[COST_W-1:0];

endmodule

// ===== sv/rrg_datapath.sv =====
// rrg_datapath: cost windows, running sums, averages, rate decision and result register
// depends on rrg_pkg and rrg_divider
module rrg_datapath import rrg_pkg::*; #(
   parameter int CALC_DEPTH = CALC_DEPTH_DEF,
   parameter int DRAW_DEPTH = DRAW_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_data,
   input  cfg_type    cfg,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam int MAX_D   = (CALC_DEPTH > DRAW_DEPTH) ? CALC_DEPTH : DRAW_DEPTH;
   localparam int CSUM_W  = COST_W + $clog2(CALC_DEPTH);
   localparam int DSUM_W  = COST_W + $clog2(DRAW_DEPTH);
   localparam int SUM_W   = (CSUM_W > DSUM_W) ? CSUM_W : DSUM_W;
   localparam int CNT_W   = $clog2(MAX_D + 1);
   localparam int CCNT_W  = $clog2(CALC_DEPTH + 1);
   localparam int DCNT_W  = $clog2(DRAW_DEPTH + 1);
   localparam int CHEAD_W = $clog2(CALC_DEPTH);
   localparam int DHEAD_W = (DRAW_DEPTH > 1) ? $clog2(DRAW_DEPTH) : 1;

   function automatic logic [COST_W-1:0] clamp_cost(input logic [AMT_W-1:0] v);
      logic [COST_W-1:0] r;
      if (v > AMT_W'(COST_CLAMP)) begin
         r = COST_CLAMP;
      end else begin
         r = v[COST_W-1:0];
      end
      return r;
   endfunction

   // item and accumulators
   req_type           item_ff;
   logic [COST_W-1:0] pending_ff;
   logic [AMT_W-1:0]  wait_ff;
   logic [COST_W-1:0] new_val_ff;
   logic [COST_W-1:0] draw_avg_ff;
   logic [EST_W-1:0]  est_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [TICK_W-1:0] last_ff;
   logic              owned_ff;
   logic [RATE_W-1:0] saved_ff;

   // windows
   logic [COST_W-1:0]  calc_mem [CALC_DEPTH];
   logic [COST_W-1:0]  draw_mem [DRAW_DEPTH];
   logic [COST_W-1:0]  calc_rd_ff, draw_rd_ff;
   logic [CHEAD_W-1:0] calc_head_ff;
   logic [DHEAD_W-1:0] draw_head_ff;
   logic [CCNT_W-1:0]  calc_count_ff, calc_count_in;
   logic [DCNT_W-1:0]  draw_count_ff, draw_count_in;
   logic [CSUM_W-1:0]  calc_sum_ff, calc_sum_in;
   logic [DSUM_W-1:0]  draw_sum_ff, draw_sum_in;
   logic               calc_full, draw_full, is_tick;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [AMT_W:0]    wait_sum;
   logic [AMT_W-1:0]  net_cost;
   logic [SUM_W-1:0]  div_dividend;
   logic [CNT_W-1:0]  div_divisor;
   logic              div_done;
   logic [COST_W-1:0] div_quotient;

   // decision terms
   logic [RATE_W-1:0] mode, forced, wanted, rate_v, saved_in;
   logic              burst_en, owned_in, set_v, clr_burst, clr_auto, calc_clear;
   logic              full_eff, dwell_ok;
   logic [TICK_W-1:0] last_eff;

   assign is_tick   = (item_ff.kind == KIND_TICK);
   assign calc_full = (calc_count_ff == CCNT_W'(CALC_DEPTH));
   assign draw_full = (draw_count_ff == DCNT_W'(DRAW_DEPTH));
   assign wait_sum  = {1'b0, wait_ff} + {1'b0, req_data.amount_us};
   assign net_cost  = (item_ff.amount_us > wait_ff) ? (item_ff.amount_us - wait_ff) : '0;

   assign calc_sum_in   = calc_sum_ff - (calc_full ? CSUM_W'(calc_rd_ff) : '0)
                          + CSUM_W'(new_val_ff);
   assign draw_sum_in   = draw_sum_ff - (draw_full ? DSUM_W'(draw_rd_ff) : '0)
                          + DSUM_W'(new_val_ff);
   assign calc_count_in = calc_full ? calc_count_ff : calc_count_ff + 1'b1;
   assign draw_count_in = draw_full ? draw_count_ff : draw_count_ff + 1'b1;

   assign div_dividend = is_tick ? SUM_W'(calc_sum_in) : SUM_W'(draw_sum_in);
   assign div_divisor  = is_tick ? CNT_W'(calc_count_in) : CNT_W'(draw_count_in);

   rrg_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // notes
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         wait_ff    <= '0;
      end else if (cmd.accept) begin
         priority case (req_data.kind)
            KIND_CALC: pending_ff <= clamp_cost(req_data.amount_us);
            KIND_WAIT: wait_ff    <= wait_sum[AMT_W] ? '1 : wait_sum[AMT_W-1:0];
            default: ;
         endcase
      end else if (cmd.read && item_ff.kind == KIND_DRAW) begin
         wait_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
      end
      if (cmd.read) begin
         new_val_ff <= is_tick ? pending_ff : clamp_cost(net_cost);
      end
   end

   // window memories
   always_ff @(posedge clock) begin
      if (cmd.update && is_tick) begin
         calc_mem[calc_head_ff] <= new_val_ff;
      end
      calc_rd_ff <= calc_mem[calc_head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.update && item_ff.kind == KIND_DRAW) begin
         draw_mem[draw_head_ff] <= new_val_ff;
      end
      draw_rd_ff <= draw_mem[draw_head_ff];
   end

   // calc window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         calc_head_ff  <= '0;
         calc_count_ff <= '0;
         calc_sum_ff   <= '0;
         tick_ff       <= '0;
         last_ff       <= '0;
      end else if (cmd.update && is_tick) begin
         calc_head_ff  <= (calc_head_ff == CHEAD_W'(CALC_DEPTH - 1)) ? '0
                          : calc_head_ff + 1'b1;
         calc_count_ff <= calc_count_in;
         calc_sum_ff   <= calc_sum_in;
         tick_ff       <= tick_ff + 1'b1;
      end else if (cmd.decide && calc_clear) begin
         calc_head_ff  <= '0;
         calc_count_ff <= '0;
         calc_sum_ff   <= '0;
         last_ff       <= tick_ff;
      end
   end

   // draw window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         draw_head_ff  <= '0;
         draw_count_ff <= '0;
         draw_sum_ff   <= '0;
         draw_avg_ff   <= '0;
      end else if (cmd.update && item_ff.kind == KIND_DRAW) begin
         draw_head_ff  <= (draw_head_ff == DHEAD_W'(DRAW_DEPTH - 1)) ? '0
                          : draw_head_ff + 1'b1;
         draw_count_ff <= draw_count_in;
         draw_sum_ff   <= draw_sum_in;
      end else if (cmd.finish && item_ff.kind == KIND_DRAW) begin
         draw_avg_ff <= div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && is_tick) begin
         est_ff <= {1'b0, div_quotient} + {1'b0, draw_avg_ff};
      end
   end

   // rate decision
   always_comb begin
      mode      = (item_ff.current_rate == RATE_BAD) ? RATE_SLOW : item_ff.current_rate;
      forced    = (cfg.burst_rate == RATE_BAD) ? RATE_SLOW : cfg.burst_rate;
      burst_en  = (forced != RATE_FAST) && !item_ff.manual_override;
      owned_in  = owned_ff;
      saved_in  = saved_ff;
      set_v     = 1'b0;
      rate_v    = RATE_FAST;
      clr_burst = 1'b0;
      clr_auto  = 1'b0;
      if (burst_en) begin
         if (item_ff.burst_active && !owned_ff) begin
            owned_in = 1'b1;
            saved_in = mode;
            if (mode != forced) begin
               set_v  = 1'b1;
               rate_v = forced;
            end
         end else if (!item_ff.burst_active && owned_ff) begin
            owned_in  = 1'b0;
            set_v     = 1'b1;
            rate_v    = saved_ff;
            clr_burst = 1'b1;
         end
      end
      full_eff = calc_full && !clr_burst;
      last_eff = clr_burst ? tick_ff : last_ff;
      dwell_ok = (tick_ff - last_eff) >= TICK_W'(cfg.dwell_ticks);
      wanted   = mode;
      priority if (mode == RATE_FAST && est_ff > cfg.demote_fast_to_mid_us) begin
         wanted = RATE_MID;
      end else if (mode == RATE_MID && est_ff > cfg.demote_mid_to_slow_us) begin
         wanted = RATE_SLOW;
      end else if (mode == RATE_MID && est_ff < cfg.promote_mid_to_fast_us) begin
         wanted = RATE_FAST;
      end else if (mode == RATE_SLOW && est_ff < cfg.promote_slow_to_mid_us) begin
         wanted = RATE_MID;
      end else begin
         wanted = mode;
      end
      if (!(burst_en && owned_in) && full_eff && !item_ff.manual_override && dwell_ok
          && wanted != mode) begin
         set_v    = 1'b1;
         rate_v   = wanted;
         clr_auto = 1'b1;
      end
      calc_clear = clr_burst || clr_auto;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff <= 1'b0;
         saved_ff <= RATE_FAST;
      end else if (cmd.decide) begin
         owned_ff <= owned_in;
         saved_ff <= saved_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_data_ff.set_request  <= set_v;
         rsp_data_ff.new_rate     <= set_v ? rate_v : RATE_FAST;
         rsp_data_ff.estimate_us  <= est_ff;
         rsp_data_ff.burst_forced <= owned_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.item_kind = item_ff.kind;
   assign status.div_done  = div_done;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   a_decide_has_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over an untaken result");

   a_decide_on_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> item_ff.kind == KIND_TICK)
      else $error("result produced for a note");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && calc_clear) |=> (calc_count_ff == '0 && calc_head_ff == '0))
      else $error("calc window not emptied after a switch");

   a_draw_avg_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && item_ff.kind == KIND_DRAW) |=> draw_avg_ff <= COST_CLAMP)
      else $error("draw average above the cost clamp");

   a_burst_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> rsp_data_ff.burst_forced == owned_ff)
      else $error("burst flag disagrees with ownership");

endmodule

// ===== sv/render_rate_governor_unit.sv =====
// render_rate_governor_unit: one item at a time; calc and wait notes are taken in idle,
// draw notes pass read, update, divide and finish, and ticks then add a decide step
// that waits for a free result slot; the shared two-bit-per-cycle divider forming the
// window averages takes STEPS steps: half the running-sum width rounded up, 11 by default.
// a tick's result sits in an output register and can wait while the next item runs.
// synchronous active-high reset clears control, counters, sums, config and the result valid flag; no clearing pass
module render_rate_governor_unit import rrg_pkg::*; #(
   parameter int CALC_DEPTH = CALC_DEPTH_DEF,
   parameter int DRAW_DEPTH = DRAW_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rrg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rrg_datapath #(
      .CALC_DEPTH (CALC_DEPTH),
      .DRAW_DEPTH (DRAW_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
